@@ hdl/periodic_task_dispatch_table_unit_defines.svh @@
// Assertion macros shared by the dispatch table unit.
`ifndef PERIODIC_TASK_DISPATCH_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TASK_DISPATCH_TABLE_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PTDT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dispatch table check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PTDT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dispatch table check failed");

`endif

@@ hdl/ptdt_pkg.sv @@
// Package with the types and constants of the dispatch table unit.
package ptdt_pkg;

   localparam int NUM_ENTRIES  = 32;
   localparam int IDX_W        = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int MAX_DISPATCH = 32;
   localparam int DISP_W       = $clog2(MAX_DISPATCH + 1);

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;

   localparam logic [15:0] INHIBIT_BIT = 16'h8000;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Laid out so that the lowest field sits in the lowest bits.
   typedef struct packed {
      logic signed [15:0] initial_count;
      logic [7:0]         case_number;
      logic [15:0]        period_word;
      logic [4:0]         entry_index;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  case_number;
      logic [15:0] period_word;
      logic [15:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [7:0] dispatch_case;
      logic [4:0] dispatch_entry;
      logic       dispatched;
      logic       last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CLOSE
   } state_type;

endpackage

@@ hdl/periodic_task_dispatch_table_unit.sv @@
// Periodic task dispatch table: a 32-entry rate scheduler in one table memory.
//
// A load item (tuser high) writes one table entry and gives no result; the
// next item can follow in the next cycle. A tick item (tuser low) walks the
// table from entry 0 upward, one entry per cycle while the result side keeps
// up, and stops early at an entry whose count runs out with a zero period.
// Each entry goes through a read-modify-write of the table RAM, and the next
// entry is read while the current one is written back. The tick ends with a
// closing item marked by tlast. The table is empty after reset without a
// clearing pass: per-entry valid flags make unwritten entries read as zero.
`include "periodic_task_dispatch_table_unit_defines.svh"

module periodic_task_dispatch_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // entry_index [4:0], period_word [20:5], case_number [28:21],
   // initial_count [44:29], zero [47:45]
   input  logic [ptdt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // cmd [0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // dispatch_case [7:0], dispatch_entry [12:8], zero [15:13]
   output logic [ptdt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // dispatched [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import ptdt_pkg::*;

   req_item_type req_item;
   rsp_item_type res_item, out_item;
   logic         res_valid, out_ready;

   assign req_item = req_tdata[$bits(req_item_type)-1:0];

   ptdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser),
      .req_item  (req_item),
      .req_ready (req_tready),
      .out_ready (out_ready),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   ptdt_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_item   (res_item),
      .in_ready  (out_ready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {3'b000, out_item.dispatch_entry, out_item.dispatch_case};
   assign rsp_tuser = out_item.dispatched;
   assign rsp_tlast = out_item.last;

   // No result comes from the sequencer while it is free to take a new item.
   `PTDT_ASSERT_SAME(a_idle_no_result, req_tready, !res_valid)
   // A tick holds off the input for at least the cycle after it is taken.
   `PTDT_ASSERT_NEXT(a_tick_busy, req_tvalid && req_tready && (req_tuser == CMD_TICK), !req_tready)
   // The closing item carries no dispatch.
   `PTDT_ASSERT_SAME(a_close_clean, res_valid && res_item.last, !res_item.dispatched)

endmodule

@@ hdl/ptdt_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module ptdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ptdt_ctrl.sv @@
// Scan sequencer: loads entries and walks the table once per tick.
module ptdt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_cmd,
   input  ptdt_pkg::req_item_type    req_item,
   output logic                      req_ready,
   input  logic                      out_ready,
   output logic                      res_valid,
   output ptdt_pkg::rsp_item_type    res_item
);
   import ptdt_pkg::*;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [DISP_W-1:0]    disp_cnt_ff, disp_cnt_in;
   logic [NUM_ENTRIES-1:0] valid_ff, valid_in;
   logic                 rd_valid_ff, rd_valid_in;

   logic                 wr_en, rd_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr;
   entry_type            wr_data;
   logic [ENTRY_W-1:0]   rd_raw;

   entry_type            ent;
   logic [15:0]          cnt_dec, new_cnt;
   logic                 cnt_pos, zero_stop, fire, emit;

   ptdt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // An entry never written since reset reads as all zero.
   assign ent       = rd_valid_ff ? entry_type'(rd_raw) : '0;
   assign cnt_dec   = ent.count - 16'd1;
   assign cnt_pos   = (cnt_dec != 16'd0) && ((cnt_dec & INHIBIT_BIT) == 16'd0);
   assign zero_stop = !cnt_pos && (ent.period_word == 16'd0);
   assign fire      = !cnt_pos && (ent.period_word != 16'd0)
                      && ((ent.period_word & INHIBIT_BIT) == 16'd0);
   assign emit      = fire && (disp_cnt_ff < DISP_W'(MAX_DISPATCH));

   always_comb begin
      if (cnt_pos) begin
         new_cnt = cnt_dec;
      end else if (zero_stop) begin
         new_cnt = 16'd1;
      end else if ((ent.period_word & INHIBIT_BIT) != 16'd0) begin
         new_cnt = ent.period_word & ~INHIBIT_BIT;
      end else begin
         new_cnt = ent.period_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         disp_cnt_ff <= '0;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         disp_cnt_ff <= disp_cnt_in;
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      disp_cnt_in = disp_cnt_ff;
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      req_ready   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = idx_ff;
      res_valid   = 1'b0;
      res_item    = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_LOAD) begin
                  if (int'(req_item.entry_index) < NUM_ENTRIES) begin
                     wr_en               = 1'b1;
                     wr_addr             = IDX_W'(req_item.entry_index);
                     wr_data.count       = req_item.initial_count;
                     wr_data.period_word = req_item.period_word;
                     wr_data.case_number = req_item.case_number;
                     valid_in[wr_addr]   = 1'b1;
                  end
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = '0;
                  rd_valid_in = valid_ff[0];
                  idx_in      = '0;
                  disp_cnt_in = '0;
                  state_in    = ST_EVAL;
               end
            end
         end

         ST_EVAL: begin
            // A dispatch waits here until the output stage can take it.
            if (!emit || out_ready) begin
               wr_en               = 1'b1;
               wr_addr             = idx_ff;
               wr_data.count       = new_cnt;
               wr_data.period_word = ent.period_word;
               wr_data.case_number = ent.case_number;
               valid_in[idx_ff]    = 1'b1;
               if (emit) begin
                  res_valid               = 1'b1;
                  res_item.dispatch_case  = ent.case_number;
                  res_item.dispatch_entry = 5'(idx_ff);
                  res_item.dispatched     = 1'b1;
                  disp_cnt_in             = disp_cnt_ff + DISP_W'(1);
               end
               if (zero_stop || (idx_ff == IDX_W'(NUM_ENTRIES - 1))) begin
                  state_in = ST_CLOSE;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = idx_ff + IDX_W'(1);
                  rd_valid_in = valid_ff[rd_addr];
                  idx_in      = rd_addr;
               end
            end
         end

         ST_CLOSE: begin
            res_valid     = 1'b1;
            res_item.last = 1'b1;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/ptdt_out.sv @@
// Output register that holds one result item until the consumer takes it.
module ptdt_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  ptdt_pkg::rsp_item_type in_item,
   output logic                   in_ready,
   output logic                   out_valid,
   output ptdt_pkg::rsp_item_type out_item,
   input  logic                   out_ready
);
   import ptdt_pkg::*;

   rsp_item_type item_ff;
   logic         valid_ff, valid_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the periodic task dispatch table unit.
module testbench;
   import ptdt_pkg::*;

   localparam int REQ_ITEM_W = $bits(req_item_type);

   // Mirror of the dispatch table with the queue of results still owed by the block.
   class dispatch_ledger;
      logic [15:0]  count_tbl  [NUM_ENTRIES];
      logic [15:0]  period_tbl [NUM_ENTRIES];
      logic [7:0]   case_tbl   [NUM_ENTRIES];
      rsp_item_type awaited [$];
      int           errors;

      function new();
         foreach (count_tbl[i]) begin
            count_tbl[i]  = '0;
            period_tbl[i] = '0;
            case_tbl[i]   = '0;
         end
         errors = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_item(input logic cmd, input req_item_type item);
         logic [15:0]  cnt;
         logic [15:0]  per;
         int           fired;
         rsp_item_type res;
         if (cmd == CMD_LOAD) begin
            count_tbl[item.entry_index]  = item.initial_count;
            period_tbl[item.entry_index] = item.period_word;
            case_tbl[item.entry_index]   = item.case_number;
            return;
         end
         fired = 0;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            cnt = count_tbl[i] - 16'd1;
            per = period_tbl[i];
            if (cnt == 16'd0 || cnt[15]) begin
               if (per == 16'd0) begin
                  // A zero period parks the entry at one and cuts the scan short.
                  count_tbl[i] = 16'd1;
                  break;
               end
               if ((per & INHIBIT_BIT) != 16'd0) begin
                  cnt = {1'b0, per[14:0]};
               end else begin
                  cnt = per;
                  if (fired < MAX_DISPATCH) begin
                     res.dispatch_case  = case_tbl[i];
                     res.dispatch_entry = 5'(i);
                     res.dispatched     = 1'b1;
                     res.last           = 1'b0;
                     awaited.push_back(res);
                     fired++;
                  end
               end
            end
            count_tbl[i] = cnt;
         end
         res = '0;
         res.last = 1'b1;
         awaited.push_back(res);
      endfunction

      function void check_result(input logic [7:0] dcase, input logic [4:0] dentry,
                                 input logic disp, input logic fin);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result item: case %0d entry %0d dispatched %0d last %0d",
                   dcase, dentry, disp, fin);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (dcase !== want.dispatch_case) begin
            $error("dispatch_case: expected %0d, got %0d", want.dispatch_case, dcase);
            errors++;
         end
         if (dentry !== want.dispatch_entry) begin
            $error("dispatch_entry: expected %0d, got %0d", want.dispatch_entry, dentry);
            errors++;
         end
         if (disp !== want.dispatched) begin
            $error("dispatched: expected %0d, got %0d", want.dispatched, disp);
            errors++;
         end
         if (fin !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, fin);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   // While set, neither side inserts idle cycles.
   bit                     steady = 1'b0;
   dispatch_ledger         ledger = new();

   periodic_task_dispatch_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("periodic_task_dispatch_table_unit: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.check_result(rsp_tdata[7:0], rsp_tdata[12:8], rsp_tuser, rsp_tlast);
      end
      rsp_tready <= steady || ($urandom_range(0, 99) >= 27);
   end

   task automatic send_item(input logic cmd, input req_item_type item);
      int gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(0, 99) < 27) gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_TDATA_W'(item);
      do @(posedge clock); while (!req_tready);
      ledger.note_item(cmd, item);
   endtask

   // The payload of a tick is meaningless, so it carries random noise.
   task automatic send_tick();
      send_item(CMD_TICK, REQ_ITEM_W'({$urandom, $urandom}));
   endtask

   task automatic load_entry(input logic [4:0] idx, input logic [15:0] per,
                             input logic [7:0] cs, input logic [15:0] cnt);
      req_item_type item;
      item.entry_index   = idx;
      item.period_word   = per;
      item.case_number   = cs;
      item.initial_count = cnt;
      send_item(CMD_LOAD, item);
   endtask

   // Mostly short periods and small counts so that entries fire often.
   function automatic req_item_type random_entry(input logic [4:0] idx);
      req_item_type item;
      int           pick;
      item.entry_index = idx;
      item.case_number = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         item.period_word = 16'($urandom_range(1, 6));
      end else if (pick < 82) begin
         item.period_word = INHIBIT_BIT | 16'($urandom_range(0, 6));
      end else if (pick < 85) begin
         item.period_word = 16'd0;
      end else begin
         item.period_word = 16'($urandom);
      end
      if ($urandom_range(0, 99) < 80) begin
         item.initial_count = 16'($urandom_range(0, 10) - 3);
      end else begin
         item.initial_count = 16'($urandom);
      end
      return item;
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, field extremes, inhibited and zero periods.
      send_tick();
      load_entry(5'd0, 16'd1, 8'hFF, 16'h0000);
      send_tick();
      load_entry(5'd1, 16'h7FFF, 8'h00, 16'h7FFF);
      load_entry(5'd2, 16'hFFFF, 8'hAA, 16'h8000);
      load_entry(5'd3, 16'h8000, 8'h55, 16'h0001);
      load_entry(5'd4, 16'd2, 8'h0F, 16'hFFFF);
      load_entry(5'd31, 16'hFFFF, 8'hFF, 16'h0000);
      send_tick();
      send_tick();
      load_entry(5'd5, 16'd0, 8'h12, 16'd5);
      send_tick();
      load_entry(5'd6, 16'd3, 8'h00, 16'h8000);
      load_entry(5'd0, 16'd1, 8'h80, 16'h8001);
      send_tick();
      send_tick();
      send_tick();

      // Fill the whole table so that scans run deep, then mix loads and ticks.
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         send_item(CMD_LOAD, random_entry(5'(k)));
      end
      for (int k = 0; k < 220; k++) begin
         steady = (k >= 80 && k < 150);
         if ($urandom_range(0, 99) < 40) begin
            send_tick();
         end else begin
            send_item(CMD_LOAD, random_entry(5'($urandom_range(0, NUM_ENTRIES - 1))));
         end
      end
      steady = 1'b0;
      send_tick();
      req_tvalid <= 1'b0;

      while (ledger.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("periodic_task_dispatch_table_unit: match");
      end else begin
         $display("periodic_task_dispatch_table_unit: mismatch");
      end
      $finish;
   end

endmodule
